// File: src/hcd_pkg.sv
// Shared types and constants for the chunked-body decoder.
package hcd_pkg;

	localparam int LEN_BITS = 24;
	localparam int CLEN_W = 24;
	localparam int CFG_W = 24;
	localparam int CMP_W = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] ADDR_DELIVER_LIMIT = PADDR_W'(0);
	localparam logic [CFG_W-1:0] DELIVER_LIMIT_RST = {CFG_W{1'b1}};

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef enum logic [1:0] {
		PH_SIZE  = 2'd0,
		PH_DATA  = 2'd1,
		PH_TRAIL = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_HEADER = 2'd2,
		KIND_FINAL  = 2'd3
	} kind_t;

	// One classified byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] nibble;
		logic       is_cr;
		logic       is_lf;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]        out_byte;
		kind_t             kind;
		logic [CLEN_W-1:0] chunk_length;
		logic              last_in_chunk;
		logic              size_overflow;
	} result_t;

endpackage

// File: src/hcd_front.sv
// Front end: accept input bytes and classify them for the back end.
module hcd_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          q_push,
	output hcd_pkg::item_t q_item
);
	import hcd_pkg::*;

	logic       hex_ok;
	logic [3:0] hex_val;

	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_val = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_val = 4'(in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_item.data = in_byte;
		q_item.is_hex = hex_ok;
		q_item.nibble = hex_val;
		q_item.is_cr = (in_byte == CH_CR);
		q_item.is_lf = (in_byte == CH_LF);
	end

endmodule

// File: src/hcd_queue.sv
// Short queue of classified bytes between front and back end.
module hcd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hcd_pkg::item_t push_item,
	output logic          full,
	output logic          not_empty,
	input  logic          pop,
	output hcd_pkg::item_t pop_item
);
	import hcd_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/hcd_back.sv
// Back end: chunk state machine and the output register.
module hcd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [hcd_pkg::CFG_W-1:0] deliver_limit,
	input  logic                     q_not_empty,
	input  hcd_pkg::item_t           q_item,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output hcd_pkg::result_t         res_o
);
	import hcd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] size_accum_q, size_accum_d;
	logic                after_cr_q, after_cr_d;
	logic                stopped_q, stopped_d;
	logic [LEN_BITS-1:0] bytes_left_q, bytes_left_d;
	logic [LEN_BITS-1:0] delivered_q, delivered_d;
	logic                trailer_q, trailer_d;
	logic                overflow_q, overflow_d;

	logic                out_valid_q;
	result_t             res_q;
	result_t             res_d;

	logic [LEN_BITS-1:0] bl_dec;
	logic [LEN_BITS-1:0] dc_inc;
	logic                can_deliver;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res_o = res_q;

	always_comb begin
		phase_d = phase_q;
		size_accum_d = size_accum_q;
		after_cr_d = after_cr_q;
		stopped_d = stopped_q;
		bytes_left_d = bytes_left_q;
		delivered_d = delivered_q;
		trailer_d = trailer_q;
		overflow_d = overflow_q;
		res_d = '0;
		res_d.kind = KIND_NONE;

		bl_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : '0;
		dc_inc = delivered_q + 1'b1;
		can_deliver = (CMP_W'(delivered_q) < CMP_W'(deliver_limit));

		unique case (phase_q)
			PH_DATA: begin
				bytes_left_d = bl_dec;
				if (can_deliver) begin
					delivered_d = dc_inc;
					res_d.out_byte = q_item.data;
					res_d.kind = KIND_BYTE;
					res_d.last_in_chunk = (bl_dec == '0) ||
						(CMP_W'(dc_inc) == CMP_W'(deliver_limit));
				end
				if (bl_dec == '0) begin
					phase_d = PH_TRAIL;
					trailer_d = 1'b0;
				end
			end
			PH_TRAIL: begin
				if (!trailer_q) begin
					trailer_d = 1'b1;
				end else begin
					trailer_d = 1'b0;
					phase_d = PH_SIZE;
					size_accum_d = '0;
					after_cr_d = 1'b0;
					stopped_d = 1'b0;
					overflow_d = 1'b0;
				end
			end
			default: begin
				if (q_item.is_lf && after_cr_q) begin
					res_d.chunk_length = CLEN_W'(size_accum_q);
					res_d.size_overflow = overflow_q;
					delivered_d = '0;
					trailer_d = 1'b0;
					if (size_accum_q == '0) begin
						res_d.kind = KIND_FINAL;
						bytes_left_d = '0;
						phase_d = PH_TRAIL;
					end else begin
						res_d.kind = KIND_HEADER;
						bytes_left_d = size_accum_q;
						phase_d = PH_DATA;
					end
					size_accum_d = '0;
					after_cr_d = 1'b0;
					stopped_d = 1'b0;
					overflow_d = 1'b0;
				end else begin
					if (!stopped_q && q_item.is_hex) begin
						// saturate once the next digit would not fit
						if (|size_accum_q[LEN_BITS-1 -: 4]) begin
							size_accum_d = '1;
							overflow_d = 1'b1;
						end else begin
							size_accum_d = {size_accum_q[LEN_BITS-5:0], q_item.nibble};
						end
					end else begin
						stopped_d = 1'b1;
					end
					after_cr_d = q_item.is_cr;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			size_accum_q <= '0;
			after_cr_q <= 1'b0;
			stopped_q <= 1'b0;
			bytes_left_q <= '0;
			delivered_q <= '0;
			trailer_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			size_accum_q <= size_accum_d;
			after_cr_q <= after_cr_d;
			stopped_q <= stopped_d;
			bytes_left_q <= bytes_left_d;
			delivered_q <= delivered_d;
			trailer_q <= trailer_d;
			overflow_q <= overflow_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

endmodule

// File: src/http_chunked_decoder_unit.sv
// Top level of the HTTP chunked-body decoder.
//
//  channel   signals                                    moves
//  --------  -----------------------------------------  --------------------------------
//  input     in_valid / in_ready, in_byte               one body byte per transaction
//  output    out_valid / out_ready, out_byte, kind,     one result per input byte
//            chunk_length, last_in_chunk, size_overflow
//  config    psel/penable/pwrite/paddr/pwdata/prdata    deliver_limit at byte address 0
//
// Throughput is one byte per cycle unless the output stalls; input is queued, then registered.
// The state machine pops one queue entry per cycle unless stalled; that loop sets the rate.
// A two-entry queue separates front and back, so in_ready drops only when the output
// stalls long enough to fill it. Reset clears control state and sets deliver_limit to
// all ones; no clearing pass is needed. Write deliver_limit only while the block is idle.
module http_chunked_decoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// input transactions
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_byte,
	// output transactions
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_byte,
	output logic [1:0]                   kind,
	output logic [hcd_pkg::CLEN_W-1:0]   chunk_length,
	output logic                         last_in_chunk,
	output logic                         size_overflow,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hcd_pkg::PADDR_W-1:0]  paddr,
	input  logic [hcd_pkg::PDATA_W-1:0]  pwdata,
	output logic [hcd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import hcd_pkg::*;

	logic [CFG_W-1:0] deliver_limit_q;
	logic             q_full;
	logic             q_push;
	item_t            push_item;
	logic             q_not_empty;
	logic             q_pop;
	item_t            pop_item;
	result_t          res;

	// register file: single register, always ready
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_limit_q <= DELIVER_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_DELIVER_LIMIT) begin
			deliver_limit_q <= pwdata[CFG_W-1:0];
		end
	end

	// reads of unused addresses return zero
	assign prdata = (paddr == ADDR_DELIVER_LIMIT) ? PDATA_W'(deliver_limit_q) : '0;

	// classify incoming bytes
	hcd_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// decouple front from back
	hcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_item  (pop_item)
	);

	// run the chunk state machine and hold the result until taken
	hcd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.deliver_limit (deliver_limit_q),
		.q_not_empty   (q_not_empty),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.res_o         (res)
	);

	assign out_byte = res.out_byte;
	assign kind = res.kind;
	assign chunk_length = res.chunk_length;
	assign last_in_chunk = res.last_in_chunk;
	assign size_overflow = res.size_overflow;

endmodule

// File: src/hcd_checker.sv
// Port-level checks for the chunked-body decoder, bound to the top level.
module hcd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  out_byte,
	input logic [1:0]                  kind,
	input logic [hcd_pkg::CLEN_W-1:0]  chunk_length,
	input logic                        last_in_chunk,
	input logic                        size_overflow
);
	import hcd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind) &&
			$stable(chunk_length) && $stable(last_in_chunk) && $stable(size_overflow))
		else $error("stalled output transaction changed");

	// payload fields are zero unless a byte is delivered
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> out_byte == 8'h00 && !last_in_chunk)
		else $error("payload fields set on a non-byte result");

	// length and overflow only ride on header results
	a_hdr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_BYTE || kind == KIND_NONE) |->
			chunk_length == '0 && !size_overflow)
		else $error("header fields set on a non-header result");

	// the final chunk carries a zero length
	a_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FINAL |-> chunk_length == '0 && !size_overflow)
		else $error("final chunk with nonzero length");

endmodule

bind http_chunked_decoder_unit hcd_checker u_hcd_checker (.*);
